// ----- hw/rtl/pmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsc_pkg
// Shared types and codes for the measurement session controller.
// ----------------------------------------------------------------------------
package pmsc_pkg;

  typedef enum logic [1:0] {
    CMD_RESET    = 2'd0,
    CMD_TRIGGER  = 2'd1,
    CMD_PONG     = 2'd2,
    CMD_WATCHDOG = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_RESET_XFORM = 3'd0,
    ACT_FLUSH_RX    = 3'd1,
    ACT_START       = 3'd2,
    ACT_PING        = 3'd3,
    ACT_END_OK      = 3'd4,
    ACT_END_FAIL    = 3'd5
  } action_t;

  localparam logic [2:0] REG_REMEASURE = 3'd0;
  localparam logic [2:0] REG_WATCHDOG  = 3'd1;
  localparam logic [2:0] REG_MAX_TO    = 3'd2;
  localparam logic [2:0] REG_READY     = 3'd3;

  localparam logic [31:0] REMEASURE_RESET = 32'd2000000;
  localparam logic [31:0] WATCHDOG_RESET  = 32'd250000;
  localparam logic [7:0]  MAX_TO_RESET    = 8'd3;
  localparam logic [7:0]  READY_RESET     = 8'd3;

  localparam int MAX_ACTS = 4;

  typedef struct packed {
    logic [1:0]             last_idx;
    action_t [MAX_ACTS-1:0] acts;
    logic [31:0]            ip;
    logic [15:0]            port;
    logic                   carries;
    logic [63:0]            ghost;
    logic [62:0]            send_time;
  } plan_t;

endpackage

// ----- hw/rtl/pmsc_front.sv -----
// ----------------------------------------------------------------------------
// pmsc_front
// Accepts events, updates session state and builds the action plan per event.
// ----------------------------------------------------------------------------
module pmsc_front #(
  parameter int TIME_WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          cmd,
  input  logic [62:0]         time_us,
  input  logic                peer_present,
  input  logic [31:0]         peer_ip,
  input  logic [15:0]         peer_port,
  input  logic                attempt_active,
  input  logic                pong_has_ghost,
  input  logic [63:0]         pong_ghost_us,
  input  logic [7:0]          sample_count,
  output logic                push,
  output pmsc_pkg::plan_t     plan,
  input  logic                q_ready
);
  import pmsc_pkg::*;

  localparam int TW = TIME_WIDTH;

  logic [31:0]   remeasure;
  logic [31:0]   wd_interval;
  logic [7:0]    max_to;
  logic [7:0]    ready_samp;

  logic          ref_valid, ref_valid_next;
  logic [31:0]   ref_ip, ref_ip_next;
  logic [15:0]   ref_udp, ref_udp_next;
  logic [TW-1:0] next_meas, next_meas_next;
  logic [TW-1:0] last_send, last_send_next;
  logic          have_pg, have_pg_next;
  logic [63:0]   prev_ghost, prev_ghost_next;
  logic [7:0]    tcount, tcount_next;

  logic [63:0]   now64;
  logic [TW-1:0] now;
  logic [63:0]   now_ext;
  logic [TW:0]   sum;
  logic [TW:0]   diff;
  logic [7:0]    tc_inc;
  logic          moved;
  logic          due;
  logic [2:0]    n;
  logic          take;

  assign in_ready = q_ready;
  assign take     = in_valid && in_ready;
  assign now64    = {1'b0, time_us};
  assign now      = now64[TW-1:0];
  assign now_ext  = 64'(now);
  assign sum      = {1'b0, now} + (TW+1)'(remeasure);
  assign diff     = {1'b0, now} - {1'b0, last_send};
  assign tc_inc   = (tcount == 8'hFF) ? tcount : tcount + 8'd1;
  assign moved    = ref_valid && (peer_ip != ref_ip || peer_port != ref_udp);
  assign due      = now >= next_meas;

  always_comb begin
    ref_valid_next  = ref_valid;
    ref_ip_next     = ref_ip;
    ref_udp_next    = ref_udp;
    next_meas_next  = next_meas;
    last_send_next  = last_send;
    have_pg_next    = have_pg;
    prev_ghost_next = prev_ghost;
    tcount_next     = tcount;
    n               = 3'd0;
    plan.acts       = '0;
    plan.ip         = ref_ip;
    plan.port       = ref_udp;
    plan.carries    = 1'b0;
    plan.ghost      = '0;
    plan.send_time  = now_ext[62:0];
    case (cmd)
      CMD_RESET: begin
        plan.acts[0]   = ACT_RESET_XFORM;
        n              = 3'd1;
        ref_valid_next = 1'b0;
        next_meas_next = '0;
      end
      CMD_TRIGGER: begin
        if (!peer_present) begin
          if (ref_valid) begin
            plan.acts[0]   = ACT_RESET_XFORM;
            n              = 3'd1;
            ref_valid_next = 1'b0;
            next_meas_next = '0;
          end
        end else if ((!ref_valid || moved || due) && !attempt_active) begin
          if (moved) begin
            plan.acts[n[1:0]] = ACT_RESET_XFORM;
            n = n + 3'd1;
          end
          plan.acts[n[1:0]] = ACT_FLUSH_RX;
          n = n + 3'd1;
          plan.acts[n[1:0]] = ACT_START;
          n = n + 3'd1;
          plan.acts[n[1:0]] = ACT_PING;
          n = n + 3'd1;
          plan.ip         = peer_ip;
          plan.port       = peer_port;
          ref_ip_next     = peer_ip;
          ref_udp_next    = peer_port;
          ref_valid_next  = 1'b1;
          have_pg_next    = 1'b0;
          prev_ghost_next = '0;
          tcount_next     = '0;
          next_meas_next  = sum[TW] ? '1 : sum[TW-1:0];
          last_send_next  = now;
        end
      end
      CMD_PONG: begin
        tcount_next = '0;
        n           = 3'd1;
        if (sample_count >= ready_samp) begin
          plan.acts[0] = ACT_END_OK;
        end else begin
          plan.acts[0]    = ACT_PING;
          plan.carries    = pong_has_ghost;
          plan.ghost      = pong_ghost_us;
          have_pg_next    = pong_has_ghost;
          prev_ghost_next = pong_ghost_us;
          last_send_next  = now;
        end
      end
      default: begin
        if (!diff[TW] && diff[TW-1:0] >= TW'(wd_interval)) begin
          tcount_next = tc_inc;
          n           = 3'd1;
          if (tc_inc >= max_to) begin
            plan.acts[0] = ACT_END_FAIL;
          end else begin
            plan.acts[0]   = ACT_PING;
            plan.carries   = have_pg;
            plan.ghost     = prev_ghost;
            last_send_next = now;
          end
        end
      end
    endcase
    plan.last_idx = 2'(n - 3'd1);
  end

  assign push = take && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      remeasure   <= REMEASURE_RESET;
      wd_interval <= WATCHDOG_RESET;
      max_to      <= MAX_TO_RESET;
      ready_samp  <= READY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_REMEASURE: remeasure   <= cfg_data;
        REG_WATCHDOG:  wd_interval <= cfg_data;
        REG_MAX_TO:    max_to      <= cfg_data[7:0];
        REG_READY:     ready_samp  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_valid  <= 1'b0;
      ref_ip     <= '0;
      ref_udp    <= '0;
      next_meas  <= '0;
      last_send  <= '0;
      have_pg    <= 1'b0;
      prev_ghost <= '0;
      tcount     <= '0;
    end else if (take) begin
      ref_valid  <= ref_valid_next;
      ref_ip     <= ref_ip_next;
      ref_udp    <= ref_udp_next;
      next_meas  <= next_meas_next;
      last_send  <= last_send_next;
      have_pg    <= have_pg_next;
      prev_ghost <= prev_ghost_next;
      tcount     <= tcount_next;
    end
  end

endmodule

// ----- hw/rtl/pmsc_queue.sv -----
// ----------------------------------------------------------------------------
// pmsc_queue
// Two-entry plan queue between the event front end and the action sequencer.
// ----------------------------------------------------------------------------
module pmsc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pmsc_pkg::plan_t  push_plan,
  output logic             q_ready,
  input  logic             pop,
  output logic             q_valid,
  output pmsc_pkg::plan_t  q_plan
);
  import pmsc_pkg::*;

  plan_t      mem [2];
  logic [1:0] count;
  logic       wptr;
  logic       rptr;

  assign q_ready = count != 2'd2;
  assign q_valid = count != 2'd0;
  assign q_plan  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wptr  <= 1'b0;
      rptr  <= 1'b0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/pmsc_back.sv -----
// ----------------------------------------------------------------------------
// pmsc_back
// Action sequencer: plays out one queued plan, one action per transaction.
// ----------------------------------------------------------------------------
module pmsc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pmsc_pkg::plan_t  q_plan,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       action,
  output logic [31:0]      dest_ip,
  output logic [15:0]      dest_port,
  output logic             carries_prev_ghost,
  output logic [63:0]      prev_ghost_time,
  output logic [62:0]      send_time,
  output logic             last
);
  import pmsc_pkg::*;

  plan_t      cur;
  logic       busy;
  logic [1:0] idx;
  logic       take;
  logic       fin;
  action_t    act;
  logic       is_ping;

  assign act     = cur.acts[idx];
  assign is_ping = act == ACT_PING;
  assign take    = out_valid && out_ready;
  assign fin     = take && last;
  assign pop     = q_valid && (!busy || fin);

  assign out_valid          = busy;
  assign action             = act;
  assign last               = idx == cur.last_idx;
  assign dest_ip            = is_ping ? cur.ip : '0;
  assign dest_port          = is_ping ? cur.port : '0;
  assign carries_prev_ghost = is_ping && cur.carries;
  assign prev_ghost_time    = is_ping ? cur.ghost : '0;
  assign send_time          = is_ping ? cur.send_time : '0;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fin) begin
      busy <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// ----- hw/rtl/peer_measurement_session_control_unit.sv -----
// ----------------------------------------------------------------------------
// peer_measurement_session_control_unit
// Ping/pong measurement session controller for one reference peer.
// ----------------------------------------------------------------------------
// Each accepted event is classified and applied to the session state in the
// cycle it is accepted, and its action list (one to four actions) goes into a
// two-entry queue. The sequencer emits one action per output transaction, so
// an event occupies the output for as many transactions as it has actions,
// one to four; events that cause no action are accepted and emit nothing.
// Input accepts back to back while the queue has room. Configuration writes
// are taken every cycle and should only be issued while the unit is idle.
module peer_measurement_session_control_unit #(
  parameter int TIME_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   cmd,
  input  logic [62:0]  time_us,
  input  logic         peer_present,
  input  logic [31:0]  peer_ip,
  input  logic [15:0]  peer_port,
  input  logic         attempt_active,
  input  logic         pong_has_ghost,
  input  logic signed [63:0] pong_ghost_us,
  input  logic [7:0]   sample_count,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   action,
  output logic [31:0]  dest_ip,
  output logic [15:0]  dest_port,
  output logic         carries_prev_ghost,
  output logic signed [63:0] prev_ghost_time,
  output logic [62:0]  send_time,
  output logic         last
);
  import pmsc_pkg::*;

  logic  push;
  logic  pop;
  logic  q_ready;
  logic  q_valid;
  plan_t push_plan;
  plan_t q_plan;

  assign cfg_ready = 1'b1;

  pmsc_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .time_us        (time_us),
    .peer_present   (peer_present),
    .peer_ip        (peer_ip),
    .peer_port      (peer_port),
    .attempt_active (attempt_active),
    .pong_has_ghost (pong_has_ghost),
    .pong_ghost_us  (pong_ghost_us),
    .sample_count   (sample_count),
    .push           (push),
    .plan           (push_plan),
    .q_ready        (q_ready)
  );

  pmsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_plan (push_plan),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_plan    (q_plan)
  );

  pmsc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_plan             (q_plan),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .action             (action),
    .dest_ip            (dest_ip),
    .dest_port          (dest_port),
    .carries_prev_ghost (carries_prev_ghost),
    .prev_ghost_time    (prev_ghost_time),
    .send_time          (send_time),
    .last               (last)
  );

  a_reset_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_RESET |-> push)
    else $error("epoch reset produced no action");

  a_nonping_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != ACT_PING |->
      dest_ip == '0 && dest_port == '0 && !carries_prev_ghost && send_time == '0)
    else $error("non-ping action carries payload");

  a_start_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_START |-> !last)
    else $error("start attempt without following ping");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
